// ===== rtl/mvl2_pkg.sv =====
// ============================================================================
// mvl2_pkg: shared types, constants and the CRC step for the MAVLink v2 framer
// Holds the configuration bundle, the queue entry layout, register indexes,
// header positions and the X.25 byte fold used by the back end.
// ============================================================================
package mvl2_pkg;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int MSGID_W   = 24;
    localparam int CRC_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_ID     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_EXTRA      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SYSTEM_ID      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COMPONENT_ID   = 3'd4;

    // Reset values of the registers
    localparam logic [BYTE_W-1:0]  RST_PAYLOAD_LENGTH = 8'd64;
    localparam logic [MSGID_W-1:0] RST_MESSAGE_ID     = 24'd107;
    localparam logic [BYTE_W-1:0]  RST_CRC_EXTRA      = 8'd108;
    localparam logic [BYTE_W-1:0]  RST_SYSTEM_ID      = 8'd1;
    localparam logic [BYTE_W-1:0]  RST_COMPONENT_ID   = 8'd1;

    // Framing constants
    localparam logic [BYTE_W-1:0] FRAME_MAGIC = 8'hFD;
    localparam logic [CRC_W-1:0]  CRC_INIT    = 16'hFFFF;

    // Header byte positions (magic sits at position zero)
    localparam int HDR_IDX_W = 4;
    localparam logic [HDR_IDX_W-1:0] HDR_LEN    = 4'd1;
    localparam logic [HDR_IDX_W-1:0] HDR_INCOMP = 4'd2;
    localparam logic [HDR_IDX_W-1:0] HDR_COMPAT = 4'd3;
    localparam logic [HDR_IDX_W-1:0] HDR_SEQ    = 4'd4;
    localparam logic [HDR_IDX_W-1:0] HDR_SYSID  = 4'd5;
    localparam logic [HDR_IDX_W-1:0] HDR_COMPID = 4'd6;
    localparam logic [HDR_IDX_W-1:0] HDR_MSGID0 = 4'd7;
    localparam logic [HDR_IDX_W-1:0] HDR_MSGID1 = 4'd8;
    localparam logic [HDR_IDX_W-1:0] HDR_MSGID2 = 4'd9;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Live configuration
    typedef struct packed {
        logic [BYTE_W-1:0]  payload_length;
        logic [MSGID_W-1:0] message_id;
        logic [BYTE_W-1:0]  crc_extra;
        logic [BYTE_W-1:0]  system_id;
        logic [BYTE_W-1:0]  component_id;
    } cfg_t;

    // One classified payload beat
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
        logic [BYTE_W-1:0] seq;
    } q_entry_t;

    // Length byte as sent: zero acts as one
    function automatic logic [BYTE_W-1:0] eff_length(input logic [BYTE_W-1:0] len);
        eff_length = (len == '0) ? 8'd1 : len;
    endfunction

    // X.25 CRC, one byte (MAVLink accumulate form)
    function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        crc_fold = {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
                 ^ {12'h000, t[7:4]};
    endfunction

endpackage

// ===== rtl/mavlink_v2_frame_encoder.sv =====
// ============================================================================
// mavlink_v2_frame_encoder: MAVLink v2 framer with X.25 CRC
// Wraps packed payload bytes into v2 frames: header, payload, CRC.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall / payload_byte): one payload byte per
//   beat. Output channel (out_valid / out_stall / frame_byte, last_of_run,
//   frame_end): one framed byte per beat; last_of_run marks the final byte
//   caused by an input beat, frame_end marks the CRC high byte.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
//   ready; write only while the block is idle. Unknown indexes are ignored.
//   Throughput: the output runs one byte per cycle while out_stall is low.
//   A middle payload byte yields 1 output byte, the first byte of a frame
//   11, the last byte 3, and a one-byte frame 13, as set by the back-end
//   sequencer. A 4-entry queue lets input keep flowing meanwhile.
//   Path: an accepted beat passes through the queue and the output register.
//   Reset: registers return to their defaults, sequence number and frame
//   position to zero, queue and output empty.
//   Stall: while out_stall is high the output beat holds; the queue fills and
//   in_stall rises once it holds 4 beats.
// ============================================================================
module mavlink_v2_frame_encoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  payload_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        last_of_run,
    output logic        frame_end,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import mvl2_pkg::*;

    cfg_t     cfg_reg;
    q_entry_t push_entry;
    q_entry_t head;
    logic     push;
    logic     pop;
    logic     q_empty;
    logic     q_full;
    logic     cfg_we;

    // Configuration registers
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.payload_length <= RST_PAYLOAD_LENGTH;
            cfg_reg.message_id     <= RST_MESSAGE_ID;
            cfg_reg.crc_extra      <= RST_CRC_EXTRA;
            cfg_reg.system_id      <= RST_SYSTEM_ID;
            cfg_reg.component_id   <= RST_COMPONENT_ID;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PAYLOAD_LENGTH: cfg_reg.payload_length <= cfg_data[7:0];
                REG_MESSAGE_ID:     cfg_reg.message_id     <= cfg_data;
                REG_CRC_EXTRA:      cfg_reg.crc_extra      <= cfg_data[7:0];
                REG_SYSTEM_ID:      cfg_reg.system_id      <= cfg_data[7:0];
                REG_COMPONENT_ID:   cfg_reg.component_id   <= cfg_data[7:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Intake and classification
    mvl2_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .payload_byte (payload_byte),
        .cfg          (cfg_reg),
        .q_full       (q_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    // Decoupling queue
    mvl2_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    // Framing and output
    mvl2_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head        (head),
        .q_empty     (q_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_byte  (frame_byte),
        .last_of_run (last_of_run),
        .frame_end   (frame_end)
    );

endmodule

// ===== rtl/mvl2_front.sv =====
// ============================================================================
// mvl2_front: payload intake and classification
// Accepts payload beats, tracks the position in the frame and the sequence
// number, and tags each beat as first and/or last of its frame.
// ============================================================================
module mvl2_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               payload_byte,
    input  mvl2_pkg::cfg_t           cfg,
    input  logic                     q_full,
    output logic                     push,
    output mvl2_pkg::q_entry_t       push_entry
);
    import mvl2_pkg::*;

    logic [BYTE_W-1:0] pos_reg, pos_next;
    logic [BYTE_W-1:0] seq_reg, seq_next;
    logic [BYTE_W-1:0] len_eff;
    logic              is_first;
    logic              is_last;

    // Handshake: stall only while the queue is full
    assign in_stall = q_full;
    assign push     = in_valid && !in_stall;

    // Classify the beat
    assign len_eff  = eff_length(cfg.payload_length);
    assign is_first = (pos_reg == '0);
    assign is_last  = ({1'b0, pos_reg} + 9'd1) >= {1'b0, len_eff};

    assign push_entry.data  = payload_byte;
    assign push_entry.first = is_first;
    assign push_entry.last  = is_last;
    assign push_entry.seq   = seq_reg;

    // Position and sequence update
    always_comb
    begin
        pos_next = pos_reg;
        seq_next = seq_reg;
        if (push)
        begin
            pos_next = is_last ? '0 : pos_reg + 8'd1;
            if (is_first)
            begin
                seq_next = seq_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            seq_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            seq_reg <= seq_next;
        end
    end

endmodule

// ===== rtl/mvl2_queue.sv =====
// ============================================================================
// mvl2_queue: short FIFO between front and back
// Holds classified payload beats so intake and framing stall independently.
// ============================================================================
module mvl2_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  mvl2_pkg::q_entry_t       push_entry,
    input  logic                     pop,
    output mvl2_pkg::q_entry_t       head,
    output logic                     empty,
    output logic                     full
);
    import mvl2_pkg::*;

    q_entry_t          slot_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]   count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == Q_CW'(Q_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CW'(Q_DEPTH))
        else $error("queue count exceeds depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

endmodule

// ===== rtl/mvl2_back.sv =====
// ============================================================================
// mvl2_back: frame sequencer and output stage
// Walks the queued beats, emits header, payload and CRC bytes one per cycle
// unless stalled, into a registered output, and keeps the running X.25 CRC.
// ============================================================================
module mvl2_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mvl2_pkg::cfg_t           cfg,
    input  mvl2_pkg::q_entry_t       head,
    input  logic                     q_empty,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [7:0]               frame_byte,
    output logic                     last_of_run,
    output logic                     frame_end
);
    import mvl2_pkg::*;

    typedef enum logic [4:0] {
        ST_NEXT   = 5'b00001,
        ST_HDR    = 5'b00010,
        ST_PAY    = 5'b00100,
        ST_CRC_LO = 5'b01000,
        ST_CRC_HI = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [HDR_IDX_W-1:0] idx_reg, idx_next;
    logic [CRC_W-1:0]     crc_reg, crc_next;
    logic                 out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]    byte_reg, byte_next;
    logic                 lor_reg, lor_next;
    logic                 fe_reg, fe_next;
    logic                 slot_free;
    logic                 load;
    logic [BYTE_W-1:0]    hdr_byte;
    logic [CRC_W-1:0]     crc_pay;
    logic [CRC_W-1:0]     crc_hdr;
    logic [CRC_W-1:0]     crc_xtra;

    // Output slot can take a beat when empty or draining this cycle
    assign slot_free = !out_valid_reg || !out_stall;

    // Header byte mux
    always_comb
    begin
        unique case (idx_reg)
            HDR_LEN:    hdr_byte = eff_length(cfg.payload_length);
            HDR_INCOMP: hdr_byte = 8'h00;
            HDR_COMPAT: hdr_byte = 8'h00;
            HDR_SEQ:    hdr_byte = head.seq;
            HDR_SYSID:  hdr_byte = cfg.system_id;
            HDR_COMPID: hdr_byte = cfg.component_id;
            HDR_MSGID0: hdr_byte = cfg.message_id[7:0];
            HDR_MSGID1: hdr_byte = cfg.message_id[15:8];
            HDR_MSGID2: hdr_byte = cfg.message_id[23:16];
            default:    hdr_byte = 8'h00;
        endcase
    end

    // CRC candidates
    assign crc_pay  = crc_fold(crc_reg, head.data);
    assign crc_hdr  = crc_fold(crc_reg, hdr_byte);
    assign crc_xtra = crc_fold(crc_reg, cfg.crc_extra);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        pop        = 1'b0;
        load       = 1'b0;
        byte_next  = byte_reg;
        lor_next   = lor_reg;
        fe_next    = fe_reg;
        unique case (state_reg)
            ST_NEXT:
            begin
                if (slot_free && !q_empty)
                begin
                    load = 1'b1;
                    if (head.first)
                    begin
                        byte_next  = FRAME_MAGIC;
                        lor_next   = 1'b0;
                        fe_next    = 1'b0;
                        crc_next   = CRC_INIT;
                        idx_next   = HDR_LEN;
                        state_next = ST_HDR;
                    end
                    else
                    begin
                        byte_next  = head.data;
                        lor_next   = !head.last;
                        fe_next    = 1'b0;
                        crc_next   = crc_pay;
                        pop        = 1'b1;
                        state_next = head.last ? ST_CRC_LO : ST_NEXT;
                    end
                end
            end
            ST_HDR:
            begin
                if (slot_free)
                begin
                    load      = 1'b1;
                    byte_next = hdr_byte;
                    lor_next  = 1'b0;
                    fe_next   = 1'b0;
                    crc_next  = crc_hdr;
                    idx_next  = idx_reg + 1'b1;
                    if (idx_reg == HDR_MSGID2)
                    begin
                        state_next = ST_PAY;
                    end
                end
            end
            ST_PAY:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    byte_next  = head.data;
                    lor_next   = !head.last;
                    fe_next    = 1'b0;
                    crc_next   = crc_pay;
                    pop        = 1'b1;
                    state_next = head.last ? ST_CRC_LO : ST_NEXT;
                end
            end
            ST_CRC_LO:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    crc_next   = crc_xtra;
                    byte_next  = crc_xtra[7:0];
                    lor_next   = 1'b0;
                    fe_next    = 1'b0;
                    state_next = ST_CRC_HI;
                end
            end
            ST_CRC_HI:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    byte_next  = crc_reg[15:8];
                    lor_next   = 1'b1;
                    fe_next    = 1'b1;
                    state_next = ST_NEXT;
                end
            end
            default:
            begin
                state_next = ST_NEXT;
            end
        endcase
    end

    // Output valid: set on load, cleared once the beat is taken
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_NEXT;
            idx_reg       <= '0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        lor_reg  <= lor_next;
        fe_reg   <= fe_next;
    end

    assign out_valid   = out_valid_reg;
    assign frame_byte  = byte_reg;
    assign last_of_run = lor_reg;
    assign frame_end   = fe_reg;

    // Checks
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && fe_reg) |-> lor_reg)
        else $error("frame end without end of run");

    a_crc_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CRC_LO && load) |=> (state_reg == ST_CRC_HI))
        else $error("CRC low byte not followed by high byte");

    a_hdr_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HDR) |-> (idx_reg >= HDR_LEN && idx_reg <= HDR_MSGID2))
        else $error("header index out of range");

endmodule
